FILE: rtl/d2q9_bgk_collision_assert.svh
// ----------------------------------------------------------------------------
// D2Q9 BGK collision assertion macros
// Clocked property checks used by the collision pipeline.
// ----------------------------------------------------------------------------
`ifndef D2Q9_BGK_COLLISION_ASSERT_SVH
`define D2Q9_BGK_COLLISION_ASSERT_SVH

`ifndef SYNTHESIS
`define D2Q9_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define D2Q9_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define D2Q9_ASSERT(lbl, clk, rst_n, prop, msg)
`define D2Q9_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/d2q9_pkg.sv
// ----------------------------------------------------------------------------
// D2Q9 BGK collision package
// Request and result types, lattice constants and fixed-point helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package d2q9_pkg;

	localparam int DW    = 32;
	localparam int FRAC  = 29;
	localparam int DIVN  = 31;
	localparam int NDIR  = 9;

	localparam logic [0:0] REG_RELAX = 1'b0;
	localparam logic [0:0] REG_FORCE = 1'b1;

	localparam logic [30:0] RELAX_RST = 31'd1599082897;

	typedef struct packed {
		logic signed [31:0] dist_rest;
		logic signed [31:0] dist_east;
		logic signed [31:0] dist_northeast;
		logic signed [31:0] dist_north;
		logic signed [31:0] dist_northwest;
		logic signed [31:0] dist_west;
		logic signed [31:0] dist_southwest;
		logic signed [31:0] dist_south;
		logic signed [31:0] dist_southeast;
	} d2q9_in_t;

	typedef struct packed {
		logic signed [31:0] post_rest;
		logic signed [31:0] post_east;
		logic signed [31:0] post_northeast;
		logic signed [31:0] post_north;
		logic signed [31:0] post_northwest;
		logic signed [31:0] post_west;
		logic signed [31:0] post_southwest;
		logic signed [31:0] post_south;
		logic signed [31:0] post_southeast;
		logic signed [31:0] density;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
	} d2q9_out_t;

	typedef struct packed {
		logic [8:0][31:0]   f;
		logic signed [31:0] rs;
		logic               pos;
		logic               negx;
		logic               satx;
		logic               negy;
		logic               saty;
		logic [1:0]         lowx;
		logic [1:0]         lowy;
		logic [30:0]        d;
	} div_ctx_t;

	typedef struct packed {
		logic [8:0][31:0]   f;
		logic signed [31:0] rs;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
	} keep_t;

	function automatic logic signed [1:0] ex_of(input int k);
		case (k)
			1, 2, 8: ex_of = 2'sd1;
			4, 5, 6: ex_of = -2'sd1;
			default: ex_of = 2'sd0;
		endcase
	endfunction

	function automatic logic signed [1:0] ey_of(input int k);
		case (k)
			2, 3, 4: ey_of = 2'sd1;
			6, 7, 8: ey_of = -2'sd1;
			default: ey_of = 2'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] wt_of(input int k);
		case (k)
			0:          wt_of = 32'sd477218588;
			1, 3, 5, 7: wt_of = 32'sd119304647;
			default:    wt_of = 32'sd29826162;
		endcase
	endfunction

	function automatic logic signed [31:0] sat_dw(input logic signed [71:0] v);
		if (v > 72'sd2147483647)
			sat_dw = 32'sh7FFFFFFF;
		else if (v < -72'sd2147483648)
			sat_dw = 32'sh80000000;
		else
			sat_dw = v[31:0];
	endfunction

	function automatic logic signed [33:0] eu_of(input int k, input logic signed [31:0] ux,
			input logic signed [31:0] uy);
		logic signed [33:0] sx;
		logic signed [33:0] sy;
		case (ex_of(k))
			2'sd1:   sx = 34'(ux);
			-2'sd1:  sx = -34'(ux);
			default: sx = 34'sd0;
		endcase
		case (ey_of(k))
			2'sd1:   sy = 34'(uy);
			-2'sd1:  sy = -34'(uy);
			default: sy = 34'sd0;
		endcase
		eu_of = sx + sy;
	endfunction

endpackage

FILE: rtl/d2q9_bgk_collision.sv
// ----------------------------------------------------------------------------
// D2Q9 BGK collision
// Density, velocity, equilibria and BGK relaxation for one node per request.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  node     | in        | node_valid, node_stall, node
//  result   | out       | result_valid, result_stall, result
//  cfg      | in        | cfg_we, cfg_index, cfg_data
//
//  One request per cycle while the result is not stalled; the pipeline is the 31-stage
//  restoring velocity divider plus 16 arithmetic stages.
//  Reset clears the stage valid bits and loads the register defaults.
//  A stalled result freezes the whole pipeline; node_stall follows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "d2q9_bgk_collision_assert.svh"

module d2q9_bgk_collision
	import d2q9_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        node_valid,
	output logic        node_stall,
	input  d2q9_in_t    node,
	output logic        result_valid,
	input  logic        result_stall,
	output d2q9_out_t   result,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic               en;
	logic [30:0]        relax_q;
	logic signed [31:0] force_q;
	logic signed [31:0] fin [NDIR];

	logic [8:0][31:0]   f_s1;
	logic signed [35:0] rlo_s1, rhi_s1;
	logic signed [35:0] mxp_s1, mxn_s1, myp_s1, myn_s1;
	logic               v_s1;

	logic [8:0][31:0]   f_s2;
	logic signed [31:0] rs_s2;
	logic signed [35:0] numx_s2, numy_s2;
	logic               v_s2;

	div_ctx_t           ctx_sd [0:DIVN];
	logic [30:0]        rx_sd  [0:DIVN];
	logic [30:0]        ry_sd  [0:DIVN];
	logic [30:0]        qx_sd  [0:DIVN];
	logic [30:0]        qy_sd  [0:DIVN];
	logic               vd     [0:DIVN];

	keep_t              k_s5, k_s6, k_s7, k_s8, k_s9, k_s10, k_s11;
	keep_t              k_s12, k_s13, k_s14, k_s15, k_s16, k_s17;
	logic               v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic               v_s12, v_s13, v_s14, v_s15, v_s16, v_s17;

	logic signed [33:0] eu_s6 [NDIR];
	logic [31:0]        a_s6  [NDIR];
	logic signed [33:0] eu_s7 [NDIR];
	logic [63:0]        sq_s7 [NDIR];
	logic [35:0]        eu2_s8 [NDIR];
	logic [35:0]        usq_s8;
	logic signed [36:0] base_s8 [NDIR];
	logic signed [41:0] t_s9 [NDIR];
	logic signed [36:0] base_s9 [NDIR];
	logic signed [31:0] p_s10 [NDIR];
	logic signed [63:0] prod_s11 [NDIR];
	logic signed [34:0] t1_s12 [NDIR];
	logic signed [63:0] prod_s13 [NDIR];
	logic signed [31:0] feq_s14 [NDIR];
	logic signed [32:0] diff_s15 [NDIR];
	logic signed [63:0] mul_s16 [NDIR];
	logic signed [31:0] post_s17 [NDIR];

	assign en         = !(v_s17 && result_stall);
	assign node_stall = !en;

	assign fin[0] = node.dist_rest;
	assign fin[1] = node.dist_east;
	assign fin[2] = node.dist_northeast;
	assign fin[3] = node.dist_north;
	assign fin[4] = node.dist_northwest;
	assign fin[5] = node.dist_west;
	assign fin[6] = node.dist_southwest;
	assign fin[7] = node.dist_south;
	assign fin[8] = node.dist_southeast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= RELAX_RST;
			force_q <= 32'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RELAX: relax_q <= cfg_data[30:0];
				REG_FORCE: force_q <= $signed(cfg_data);
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			vd[0] <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
		end else if (en) begin
			v_s1  <= node_valid;
			v_s2  <= v_s1;
			vd[0] <= v_s2;
			v_s5  <= vd[DIVN];
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
		end
	end

	// partial moment sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NDIR; k++)
				f_s1[k] <= fin[k];
			rlo_s1 <= 36'(fin[0]) + 36'(fin[1]) + 36'(fin[2]) + 36'(fin[3]) + 36'(fin[4]);
			rhi_s1 <= 36'(fin[5]) + 36'(fin[6]) + 36'(fin[7]) + 36'(fin[8]);
			mxp_s1 <= 36'(fin[1]) + 36'(fin[2]) + 36'(fin[8]);
			mxn_s1 <= 36'(fin[4]) + 36'(fin[5]) + 36'(fin[6]);
			myp_s1 <= 36'(fin[2]) + 36'(fin[3]) + 36'(fin[4]);
			myn_s1 <= 36'(fin[6]) + 36'(fin[7]) + 36'(fin[8]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s2    <= f_s1;
			rs_s2   <= sat_dw(72'(rlo_s1 + rhi_s1));
			numx_s2 <= mxp_s1 - mxn_s1 + 36'(force_q);
			numy_s2 <= myp_s1 - myn_s1;
		end
	end

	// divider setup
	always_ff @(posedge clk) begin
		logic [35:0] ax;
		logic [35:0] ay;
		logic [35:0] d4;
		if (en) begin
			ax = numx_s2[35] ? 36'(-numx_s2) : 36'(numx_s2);
			ay = numy_s2[35] ? 36'(-numy_s2) : 36'(numy_s2);
			d4 = {3'd0, rs_s2[30:0], 2'b00};
			ctx_sd[0].f    <= f_s2;
			ctx_sd[0].rs   <= rs_s2;
			ctx_sd[0].pos  <= (rs_s2 > 32'sd0);
			ctx_sd[0].negx <= numx_s2[35];
			ctx_sd[0].negy <= numy_s2[35];
			ctx_sd[0].satx <= (ax >= d4);
			ctx_sd[0].saty <= (ay >= d4);
			ctx_sd[0].lowx <= ax[1:0];
			ctx_sd[0].lowy <= ay[1:0];
			ctx_sd[0].d    <= rs_s2[30:0];
			rx_sd[0]       <= ax[32:2];
			ry_sd[0]       <= ay[32:2];
			qx_sd[0]       <= 31'd0;
			qy_sd[0]       <= 31'd0;
		end
	end

	for (genvar j = 0; j < DIVN; j++) begin : g_div
		logic       bx, by;
		logic [31:0] tx, ty, dd;

		always_comb begin
			bx = (j == 0) ? ctx_sd[j].lowx[1] : ((j == 1) ? ctx_sd[j].lowx[0] : 1'b0);
			by = (j == 0) ? ctx_sd[j].lowy[1] : ((j == 1) ? ctx_sd[j].lowy[0] : 1'b0);
			tx = {rx_sd[j], bx};
			ty = {ry_sd[j], by};
			dd = {1'b0, ctx_sd[j].d};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vd[j+1] <= 1'b0;
			else if (en)
				vd[j+1] <= vd[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_sd[j+1] <= ctx_sd[j];
				if (tx >= dd) begin
					rx_sd[j+1] <= 31'(tx - dd);
					qx_sd[j+1] <= {qx_sd[j][29:0], 1'b1};
				end else begin
					rx_sd[j+1] <= tx[30:0];
					qx_sd[j+1] <= {qx_sd[j][29:0], 1'b0};
				end
				if (ty >= dd) begin
					ry_sd[j+1] <= 31'(ty - dd);
					qy_sd[j+1] <= {qy_sd[j][29:0], 1'b1};
				end else begin
					ry_sd[j+1] <= ty[30:0];
					qy_sd[j+1] <= {qy_sd[j][29:0], 1'b0};
				end
			end
		end
	end

	// velocity with sign, saturation and non-positive density
	always_ff @(posedge clk) begin
		if (en) begin
			k_s5.f  <= ctx_sd[DIVN].f;
			k_s5.rs <= ctx_sd[DIVN].rs;
			if (!ctx_sd[DIVN].pos)
				k_s5.ux <= 32'sd0;
			else if (ctx_sd[DIVN].satx)
				k_s5.ux <= ctx_sd[DIVN].negx ? 32'sh80000000 : 32'sh7FFFFFFF;
			else
				k_s5.ux <= ctx_sd[DIVN].negx ? -$signed({1'b0, qx_sd[DIVN]})
					: $signed({1'b0, qx_sd[DIVN]});
			if (!ctx_sd[DIVN].pos)
				k_s5.uy <= 32'sd0;
			else if (ctx_sd[DIVN].saty)
				k_s5.uy <= ctx_sd[DIVN].negy ? 32'sh80000000 : 32'sh7FFFFFFF;
			else
				k_s5.uy <= ctx_sd[DIVN].negy ? -$signed({1'b0, qy_sd[DIVN]})
					: $signed({1'b0, qy_sd[DIVN]});
		end
	end

	always_ff @(posedge clk) begin
		logic signed [33:0] e;
		logic [33:0]        m;
		if (en) begin
			k_s6 <= k_s5;
			for (int k = 0; k < NDIR; k++) begin
				e = eu_of(k, k_s5.ux, k_s5.uy);
				m = e[33] ? 34'(-e) : 34'(e);
				eu_s6[k] <= e;
				a_s6[k]  <= (m > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : m[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s7 <= k_s6;
			for (int k = 0; k < NDIR; k++) begin
				eu_s7[k] <= eu_s6[k];
				sq_s7[k] <= 64'(a_s6[k]) * 64'(a_s6[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [64:0] s;
		logic [64:0] su;
		if (en) begin
			k_s8 <= k_s7;
			su = {1'b0, sq_s7[1]} + {1'b0, sq_s7[3]} + 65'h10000000;
			usq_s8 <= su[64:29];
			for (int k = 0; k < NDIR; k++) begin
				s = {1'b0, sq_s7[k]} + 65'h10000000;
				eu2_s8[k]  <= s[64:29];
				base_s8[k] <= 37'sd536870912 + 37'(eu_s7[k]) * 37'sd3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s9 <= k_s8;
			for (int k = 0; k < NDIR; k++) begin
				t_s9[k] <= $signed({6'd0, eu2_s8[k]}) * 42'sd9
					- $signed({6'd0, usq_s8}) * 42'sd3;
				base_s9[k] <= base_s8[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s10 <= k_s9;
			for (int k = 0; k < NDIR; k++)
				p_s10[k] <= sat_dw(72'(base_s9[k]) + 72'((t_s9[k] + 42'sd1) >>> 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s11 <= k_s10;
			for (int k = 0; k < NDIR; k++)
				prod_s11[k] <= 64'(k_s10.rs) * 64'(p_s10[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s12 <= k_s11;
			for (int k = 0; k < NDIR; k++)
				t1_s12[k] <= 35'((prod_s11[k] + 64'sd268435456) >>> FRAC);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s13 <= k_s12;
			for (int k = 0; k < NDIR; k++)
				prod_s13[k] <= 64'(t1_s12[k]) * 64'(wt_of(k));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s14 <= k_s13;
			for (int k = 0; k < NDIR; k++)
				feq_s14[k] <= sat_dw(72'((prod_s13[k] + 64'sd536870912) >>> 30));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s15 <= k_s14;
			for (int k = 0; k < NDIR; k++)
				diff_s15[k] <= 33'($signed(k_s14.f[k])) - 33'(feq_s14[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s16 <= k_s15;
			for (int k = 0; k < NDIR; k++)
				mul_s16[k] <= 64'($signed({1'b0, relax_q})) * 64'(diff_s15[k]);
		end
	end

	always_ff @(posedge clk) begin
		logic signed [33:0] dl;
		if (en) begin
			k_s17 <= k_s16;
			for (int k = 0; k < NDIR; k++) begin
				dl = 34'((mul_s16[k] + 64'sd536870912) >>> 30);
				post_s17[k] <= sat_dw(72'($signed(k_s16.f[k])) - 72'(dl));
			end
		end
	end

	assign result_valid           = v_s17;
	assign result.post_rest       = post_s17[0];
	assign result.post_east       = post_s17[1];
	assign result.post_northeast  = post_s17[2];
	assign result.post_north      = post_s17[3];
	assign result.post_northwest  = post_s17[4];
	assign result.post_west       = post_s17[5];
	assign result.post_southwest  = post_s17[6];
	assign result.post_south      = post_s17[7];
	assign result.post_southeast  = post_s17[8];
	assign result.density         = k_s17.rs;
	assign result.velocity_x      = k_s17.ux;
	assign result.velocity_y      = k_s17.uy;

	`D2Q9_ASSERT_IMPL(a_rho_zero_vel, clk, arst_n, result_valid && result.density <= 32'sd0, result.velocity_x == 32'sd0 && result.velocity_y == 32'sd0, "velocity not zero for non-positive density")
	`D2Q9_ASSERT(a_hold_s1, clk, arst_n, !en |=> $stable(v_s1) && $stable(v_s17), "pipeline moved while stalled")
	`D2Q9_ASSERT_IMPL(a_div_rem, clk, arst_n, vd[DIVN] && ctx_sd[DIVN].pos && !ctx_sd[DIVN].satx, rx_sd[DIVN] < ctx_sd[DIVN].d, "divider remainder not below divisor")

endmodule
